/* design/plcbx_pkg.sv */
// shared types and constants for the ladder-logic bit executor
package plcbx_pkg;

    localparam int CARDS    = 16;
    localparam int RELAYS   = 256;
    localparam int TIMERS   = 16;

    localparam int CARD_W   = 4;
    localparam int BIT_W    = 5;
    localparam int INDEX_W  = 16;
    localparam int VALUE_W  = 32;
    localparam int TIMER_W  = 4;
    localparam int RELAY_AW = $clog2(RELAYS);

    typedef enum logic [3:0] {
        MODE_LD    = 4'd0,
        MODE_LDI   = 4'd1,
        MODE_AND   = 4'd2,
        MODE_ANDI  = 4'd3,
        MODE_OUT   = 4'd4,
        MODE_SET   = 4'd5,
        MODE_RESET = 4'd6,
        MODE_CMP   = 4'd7,
        MODE_TICK  = 4'd8
    } mode_t;

    typedef enum logic [2:0] {
        SPACE_X     = 3'd0,
        SPACE_Y     = 3'd1,
        SPACE_M     = 3'd2,
        SPACE_N     = 3'd3,
        SPACE_TIMER = 3'd4
    } space_t;

    typedef enum logic [1:0] {
        CMP_EQ   = 2'd0,
        CMP_GT   = 2'd1,
        CMP_LT   = 2'd2,
        CMP_KEEP = 2'd3
    } cmp_kind_t;

    typedef struct packed {
        mode_t                     mode;
        space_t                    space;
        logic [CARD_W-1:0]         card;
        logic [INDEX_W-1:0]        operand_index;
        logic                      input_bit;
        logic signed [VALUE_W-1:0] value_a;
        logic signed [VALUE_W-1:0] value_b;
        cmp_kind_t                 compare_kind;
    } item_t;

    typedef struct packed {
        logic              accumulator;
        logic              write_valid;
        logic [CARD_W-1:0] write_card;
        logic [BIT_W-1:0]  write_bit;
        logic              write_value;
    } result_t;

    typedef struct packed {
        logic                we;
        logic [RELAY_AW-1:0] addr;
        logic                data;
    } relay_wr_t;

    typedef struct packed {
        logic               start;
        logic               clear;
        logic               stop;
        logic               tick;
        logic [TIMER_W-1:0] sel;
        logic [INDEX_W-1:0] preset;
    } timer_cmd_t;

endpackage

/* design/plcbx_relay_mem.sv */
// one relay store: bit memory with per-entry valid flags and write forwarding
module plcbx_relay_mem (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [plcbx_pkg::RELAY_AW-1:0] rd_addr,
    input  plcbx_pkg::relay_wr_t          wr,
    output logic                          rd_data
);

    logic mem [plcbx_pkg::RELAYS];
    logic [plcbx_pkg::RELAYS-1:0] valid_reg;
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.we) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // a write landing on the same edge as the read is passed straight through
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr.we && (wr.addr == rd_addr)) begin
                rd_data_reg <= wr.data;
            end else begin
                rd_data_reg <= valid_reg[rd_addr] & mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/plcbx_timer_bank.sv */
// on-delay timer bank: start, clear, stop and parallel tick
module plcbx_timer_bank (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  plcbx_pkg::timer_cmd_t        cmd,
    output logic [plcbx_pkg::TIMERS-1:0] done_next
);

    logic [plcbx_pkg::TIMERS-1:0]  running_reg, running_next;
    logic [plcbx_pkg::TIMERS-1:0]  finished_reg, finished_next;
    logic [plcbx_pkg::INDEX_W-1:0] elapsed_reg [plcbx_pkg::TIMERS];
    logic [plcbx_pkg::INDEX_W-1:0] elapsed_next [plcbx_pkg::TIMERS];
    logic [plcbx_pkg::INDEX_W-1:0] preset_reg [plcbx_pkg::TIMERS];
    logic [plcbx_pkg::INDEX_W-1:0] preset_next [plcbx_pkg::TIMERS];

    always_comb begin
        logic                          hit;
        logic [plcbx_pkg::INDEX_W-1:0] cnt;
        for (int t = 0; t < plcbx_pkg::TIMERS; t++) begin
            hit = (cmd.sel == plcbx_pkg::TIMER_W'(t));
            running_next[t]  = running_reg[t];
            finished_next[t] = finished_reg[t];
            elapsed_next[t]  = elapsed_reg[t];
            preset_next[t]   = preset_reg[t];
            cnt              = elapsed_reg[t];
            if (cmd.tick) begin
                if (running_reg[t] && !finished_reg[t]) begin
                    // count saturates at all ones
                    if (cnt != '1) begin
                        cnt = cnt + 1'b1;
                    end
                    elapsed_next[t] = cnt;
                    if (cnt >= preset_reg[t]) begin
                        finished_next[t] = 1'b1;
                    end
                end
            end else if (hit && cmd.clear) begin
                running_next[t]  = 1'b0;
                finished_next[t] = 1'b0;
                elapsed_next[t]  = '0;
                preset_next[t]   = '0;
            end else if (hit && cmd.start && !running_reg[t]) begin
                running_next[t]  = 1'b1;
                finished_next[t] = 1'b0;
                elapsed_next[t]  = '0;
                preset_next[t]   = cmd.preset;
            end else if (hit && cmd.stop) begin
                running_next[t]  = 1'b0;
                finished_next[t] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= '0;
            finished_reg <= '0;
            for (int t = 0; t < plcbx_pkg::TIMERS; t++) begin
                elapsed_reg[t] <= '0;
                preset_reg[t]  <= '0;
            end
        end else begin
            running_reg  <= running_next;
            finished_reg <= finished_next;
            for (int t = 0; t < plcbx_pkg::TIMERS; t++) begin
                elapsed_reg[t] <= elapsed_next[t];
                preset_reg[t]  <= preset_next[t];
            end
        end
    end

    assign done_next = finished_next;

endmodule

/* design/plcbx_exec.sv */
// instruction execute: accumulator, output image, relay and timer commands
module plcbx_exec (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  plcbx_pkg::item_t      item,
    input  logic                  m_bit,
    input  logic                  n_bit,
    output plcbx_pkg::result_t    result,
    output plcbx_pkg::relay_wr_t  m_wr,
    output plcbx_pkg::relay_wr_t  n_wr,
    output plcbx_pkg::timer_cmd_t tmr_cmd
);

    logic acc_reg, acc_next;
    logic [31:0] image_reg [plcbx_pkg::CARDS];

    logic y_ok, relay_ok, timer_ok;
    logic readable, op_bit;
    logic do_write, wval, y_we;
    logic t_start, t_clear, t_stop, t_tick;

    always_comb begin
        y_ok     = ({1'b0, item.card} < (plcbx_pkg::CARD_W + 1)'(plcbx_pkg::CARDS))
                   && (item.operand_index[plcbx_pkg::INDEX_W-1:plcbx_pkg::BIT_W] == '0);
        relay_ok = ({1'b0, item.operand_index}
                    < (plcbx_pkg::INDEX_W + 1)'(plcbx_pkg::RELAYS));
        timer_ok = ({1'b0, item.card} < (plcbx_pkg::CARD_W + 1)'(plcbx_pkg::TIMERS));

        readable = 1'b1;
        op_bit   = 1'b0;
        case (item.space)
            plcbx_pkg::SPACE_X: op_bit = y_ok & item.input_bit;
            plcbx_pkg::SPACE_Y: op_bit = y_ok
                & image_reg[item.card][item.operand_index[plcbx_pkg::BIT_W-1:0]];
            plcbx_pkg::SPACE_M: op_bit = relay_ok & m_bit;
            plcbx_pkg::SPACE_N: op_bit = relay_ok & n_bit;
            default:            readable = 1'b0;
        endcase

        acc_next = acc_reg;
        do_write = 1'b0;
        wval     = 1'b0;
        t_start  = 1'b0;
        t_clear  = 1'b0;
        t_stop   = 1'b0;
        t_tick   = 1'b0;
        unique case (item.mode) inside
            plcbx_pkg::MODE_LD, plcbx_pkg::MODE_LDI: begin
                if (readable) begin
                    acc_next = op_bit ^ (item.mode == plcbx_pkg::MODE_LDI);
                end
            end
            plcbx_pkg::MODE_AND, plcbx_pkg::MODE_ANDI: begin
                if (readable) begin
                    acc_next = acc_reg & (op_bit ^ (item.mode == plcbx_pkg::MODE_ANDI));
                end
            end
            plcbx_pkg::MODE_OUT: begin
                if (item.space == plcbx_pkg::SPACE_TIMER) begin
                    t_start = acc_reg;
                    t_clear = !acc_reg;
                end else begin
                    do_write = 1'b1;
                    wval     = acc_reg;
                end
            end
            plcbx_pkg::MODE_SET, plcbx_pkg::MODE_RESET: begin
                if (acc_reg) begin
                    if (item.space == plcbx_pkg::SPACE_TIMER) begin
                        t_stop = (item.mode == plcbx_pkg::MODE_RESET);
                    end else begin
                        do_write = 1'b1;
                        wval     = (item.mode == plcbx_pkg::MODE_SET);
                    end
                end
            end
            plcbx_pkg::MODE_CMP: begin
                if (acc_reg) begin
                    case (item.compare_kind)
                        plcbx_pkg::CMP_EQ: acc_next = (item.value_a == item.value_b);
                        plcbx_pkg::CMP_GT: acc_next = (item.value_a > item.value_b);
                        plcbx_pkg::CMP_LT: acc_next = (item.value_a < item.value_b);
                        default:           acc_next = acc_reg;
                    endcase
                end
            end
            plcbx_pkg::MODE_TICK: t_tick = 1'b1;
            default: acc_next = acc_reg;
        endcase

        y_we = do_write && (item.space == plcbx_pkg::SPACE_Y) && y_ok;

        m_wr.we   = fire && do_write && (item.space == plcbx_pkg::SPACE_M) && relay_ok;
        m_wr.addr = item.operand_index[plcbx_pkg::RELAY_AW-1:0];
        m_wr.data = wval;
        n_wr.we   = fire && do_write && (item.space == plcbx_pkg::SPACE_N) && relay_ok;
        n_wr.addr = item.operand_index[plcbx_pkg::RELAY_AW-1:0];
        n_wr.data = wval;

        tmr_cmd.start  = fire && timer_ok && t_start;
        tmr_cmd.clear  = fire && timer_ok && t_clear;
        tmr_cmd.stop   = fire && timer_ok && t_stop;
        tmr_cmd.tick   = fire && t_tick;
        tmr_cmd.sel    = item.card[plcbx_pkg::TIMER_W-1:0];
        tmr_cmd.preset = item.operand_index;

        result.accumulator = acc_next;
        result.write_valid = y_we;
        result.write_card  = y_we ? item.card : '0;
        result.write_bit   = y_we ? item.operand_index[plcbx_pkg::BIT_W-1:0] : '0;
        result.write_value = y_we & wval;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 1'b0;
            for (int c = 0; c < plcbx_pkg::CARDS; c++) begin
                image_reg[c] <= '0;
            end
        end else if (fire) begin
            acc_reg <= acc_next;
            if (y_we) begin
                image_reg[item.card][item.operand_index[plcbx_pkg::BIT_W-1:0]] <= wval;
            end
        end
    end

endmodule

/* design/plc_bit_logic_executor_core.sv */
// ladder-logic bit executor top level: input register, execute, result register
//
// Executes one ladder-logic instruction per beat on a one-bit accumulator and
// returns one result beat per instruction. A new instruction is taken every
// clock while the input is not stalled: the input register also issues the
// relay read for M and N, and the execute logic then updates the accumulator,
// output image, relays and timers and loads the result register once it is
// free or being taken. A result that is not taken holds the execute stage,
// and the input stalls only while both the input and result registers are
// full. All state, relays included, is cleared by reset with no wait before
// the first beat.
module plc_bit_logic_executor_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [3:0]          s_mode,
    input  logic [2:0]          s_space,
    input  logic [3:0]          s_card,
    input  logic [15:0]         s_operand_index,
    input  logic                s_input_bit,
    input  logic signed [31:0]  s_value_a,
    input  logic signed [31:0]  s_value_b,
    input  logic [1:0]          s_compare_kind,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_accumulator,
    output logic                m_write_valid,
    output logic [3:0]          m_write_card,
    output logic [4:0]          m_write_bit,
    output logic                m_write_value,
    output logic [15:0]         m_timers_done
);

    logic                  in_valid_reg;
    plcbx_pkg::item_t      in_item_reg;
    logic                  out_valid_reg;
    plcbx_pkg::result_t    out_res_reg;
    logic [plcbx_pkg::TIMERS-1:0] out_done_reg;

    logic                  accept, advance, fire;
    logic                  m_bit, n_bit;
    plcbx_pkg::result_t    res;
    plcbx_pkg::relay_wr_t  m_wr, n_wr;
    plcbx_pkg::timer_cmd_t tmr_cmd;
    logic [plcbx_pkg::TIMERS-1:0] done_next;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_item_reg.mode          <= plcbx_pkg::mode_t'(s_mode);
            in_item_reg.space         <= plcbx_pkg::space_t'(s_space);
            in_item_reg.card          <= s_card;
            in_item_reg.operand_index <= s_operand_index;
            in_item_reg.input_bit     <= s_input_bit;
            in_item_reg.value_a       <= s_value_a;
            in_item_reg.value_b       <= s_value_b;
            in_item_reg.compare_kind  <= plcbx_pkg::cmp_kind_t'(s_compare_kind);
        end
    end

    plcbx_relay_mem u_relay_m (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (s_operand_index[plcbx_pkg::RELAY_AW-1:0]),
        .wr      (m_wr),
        .rd_data (m_bit)
    );

    plcbx_relay_mem u_relay_n (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (s_operand_index[plcbx_pkg::RELAY_AW-1:0]),
        .wr      (n_wr),
        .rd_data (n_bit)
    );

    plcbx_exec u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .m_bit   (m_bit),
        .n_bit   (n_bit),
        .result  (res),
        .m_wr    (m_wr),
        .n_wr    (n_wr),
        .tmr_cmd (tmr_cmd)
    );

    plcbx_timer_bank u_timers (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (tmr_cmd),
        .done_next (done_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg  <= res;
            out_done_reg <= done_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_accumulator = out_res_reg.accumulator;
    assign m_write_valid = out_res_reg.write_valid;
    assign m_write_card  = out_res_reg.write_card;
    assign m_write_bit   = out_res_reg.write_bit;
    assign m_write_value = out_res_reg.write_value;
    assign m_timers_done = out_done_reg;

endmodule
